>>> rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tps assertion failed");

// next-cycle implication, disabled during reset
`define TPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tps assertion failed");

`endif

>>> rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
// constants, register codes and helpers of the track priority scorer
// no dependencies
package tps_pkg;

  localparam int TERM_FRAC_BITS = 16;
  localparam int TERM_W         = TERM_FRAC_BITS + 1;
  localparam logic [TERM_W-1:0] ONE_TERM = TERM_W'(1) << TERM_FRAC_BITS;

  localparam int HIT_FRAC_BITS = 12;
  localparam int WEIGHT_W      = 12;
  localparam int NUM_TERMS     = 5;
  localparam int PROD_W        = WEIGHT_W + TERM_W;
  localparam int SUM_W         = PROD_W + 3;

  localparam int SNR_SHIFT   = 40 - TERM_FRAC_BITS;
  localparam int REF_SHIFT   = 32 - TERM_FRAC_BITS;
  localparam int SCORE_SHIFT = TERM_FRAC_BITS - 8;

  localparam int SCORE_W = 23;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 23'd5242880;

  // square root of a 66-bit radicand, one result bit per stage
  localparam int SQ_STEPS = 33;
  localparam int RAD_W    = 66;
  localparam int ROOT_W   = 33;
  localparam int REM_W    = 34;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam logic [31:0] INV_RESET = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_TERM_WEIGHTS   = 3'd0,
    REG_INV_SNR_REF    = 3'd1,
    REG_INV_AGE_REF    = 3'd2,
    REG_INV_HALF_FIELD = 3'd3,
    REG_INV_SPEED_REF  = 3'd4,
    REG_SPEED_LIMIT    = 3'd5,
    REG_AIM_X          = 3'd6,
    REG_AIM_Y          = 3'd7
  } tps_reg_t;

  function automatic logic [TERM_W-1:0] clamp_term(input logic [63:0] v);
    return (v > 64'(ONE_TERM)) ? ONE_TERM : v[TERM_W-1:0];
  endfunction

endpackage

>>> rtl/core/track_priority_score.sv
`timescale 1ns / 1ps
// track priority scorer: five clamped terms, weighted and summed, per request
// depends on tps_pkg
// pipeline: 3 front stages, 33 square-root stages, a multiply stage,
//   a weighting stage, output register; from request acceptance to score_valid
// throughput: one request per cycle, stalls apart, set by the one-bit-per-stage
//   root pipeline; stalls hold the whole pipe; an output skid register keeps
//   taking requests while one score waits
// rst (synchronous) clears all valid bits and loads register reset values
module track_priority_score import tps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // request channel
  input  logic                  track_valid,
  output logic                  track_ready,
  input  logic                  track_alive,
  input  logic [15:0]           mean_brightness,
  input  logic [12:0]           hit_ratio,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic [15:0]           age_count,
  input  logic [31:0]           rel_speed,
  // result channel
  output logic                  score_valid,
  input  logic                  score_ready,
  output logic [SCORE_W-1:0]    score
);

  // terms that ride alongside the root pipeline
  typedef struct packed {
    logic              alive;
    logic [TERM_W-1:0] t_snr;
    logic [TERM_W-1:0] t_stab;
    logic [TERM_W-1:0] t_age;
    logic [TERM_W-1:0] t_motion;
  } side_t;

  // ---------------------------------------------------------------------------
  // configuration registers, 8-byte spacing
  // ---------------------------------------------------------------------------
  logic [NUM_TERMS*WEIGHT_W-1:0] term_weights;
  logic [31:0] inv_snr_ref;
  logic [31:0] inv_age_ref;
  logic [31:0] inv_half_field;
  logic [31:0] inv_speed_ref;
  logic [31:0] speed_limit;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;

  tps_reg_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = tps_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_weights   <= '0;
      inv_snr_ref    <= INV_RESET;
      inv_age_ref    <= INV_RESET;
      inv_half_field <= INV_RESET;
      inv_speed_ref  <= INV_RESET;
      speed_limit    <= '0;
      aim_x          <= '0;
      aim_y          <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TERM_WEIGHTS:   term_weights   <= pwdata[NUM_TERMS*WEIGHT_W-1:0];
        REG_INV_SNR_REF:    inv_snr_ref    <= pwdata[31:0];
        REG_INV_AGE_REF:    inv_age_ref    <= pwdata[31:0];
        REG_INV_HALF_FIELD: inv_half_field <= pwdata[31:0];
        REG_INV_SPEED_REF:  inv_speed_ref  <= pwdata[31:0];
        REG_SPEED_LIMIT:    speed_limit    <= pwdata[31:0];
        REG_AIM_X:          aim_x          <= pwdata[31:0];
        REG_AIM_Y:          aim_y          <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_TERM_WEIGHTS:   prdata = CFG_DATA_W'(term_weights);
      REG_INV_SNR_REF:    prdata = CFG_DATA_W'(inv_snr_ref);
      REG_INV_AGE_REF:    prdata = CFG_DATA_W'(inv_age_ref);
      REG_INV_HALF_FIELD: prdata = CFG_DATA_W'(inv_half_field);
      REG_INV_SPEED_REF:  prdata = CFG_DATA_W'(inv_speed_ref);
      REG_SPEED_LIMIT:    prdata = CFG_DATA_W'(speed_limit);
      REG_AIM_X:          prdata = CFG_DATA_W'(aim_x);
      REG_AIM_Y:          prdata = CFG_DATA_W'(aim_y);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipe advance: every stage moves together unless the skid register is full
  // ---------------------------------------------------------------------------
  logic skid_v;
  logic adv;

  assign adv         = !skid_v;
  assign track_ready = adv;

  // ---------------------------------------------------------------------------
  // stage 1: capture the request and take offsets from boresight
  // ---------------------------------------------------------------------------
  logic signed [32:0] dx, dy;
  logic [32:0]        dx_neg, dy_neg;
  logic [31:0]        ax, ay;

  assign dx     = {pos_x[31], pos_x} - {aim_x[31], aim_x};
  assign dy     = {pos_y[31], pos_y} - {aim_y[31], aim_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  // magnitude always fits 32 bits
  assign ax     = dx[32] ? dx_neg[31:0] : dx[31:0];
  assign ay     = dy[32] ? dy_neg[31:0] : dy[31:0];

  logic        s1_v;
  logic        s1_alive;
  logic [31:0] s1_ax, s1_ay;
  logic [15:0] s1_bright;
  logic [12:0] s1_hits;
  logic [15:0] s1_age;
  logic [31:0] s1_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= track_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_alive  <= track_alive;
      s1_ax     <= ax;
      s1_ay     <= ay;
      s1_bright <= mean_brightness;
      s1_hits   <= hit_ratio;
      s1_age    <= age_count;
      s1_speed  <= rel_speed;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: squares of the offsets and the reciprocal products
  // ---------------------------------------------------------------------------
  logic        s2_v;
  logic        s2_alive;
  logic [63:0] s2_sx, s2_sy;
  logic [47:0] s2_pb, s2_pa;
  logic [63:0] s2_pm;
  logic        s2_over;
  logic [12:0] s2_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_alive <= s1_alive;
      s2_sx    <= 64'(s1_ax) * 64'(s1_ax);
      s2_sy    <= 64'(s1_ay) * 64'(s1_ay);
      s2_pb    <= 48'(s1_bright) * 48'(inv_snr_ref);
      s2_pa    <= 48'(s1_age) * 48'(inv_age_ref);
      s2_pm    <= 64'(s1_speed) * 64'(inv_speed_ref);
      // speed limit of zero turns the check off
      s2_over  <= (speed_limit != 32'd0) && (s1_speed > speed_limit);
      s2_hits  <= s1_hits;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: radicand and the four terms that need no root
  // ---------------------------------------------------------------------------
  logic             s3_v;
  logic [RAD_W-1:0] s3_val;
  side_t            s3_side;
  side_t            s3_side_next;

  always_comb begin
    s3_side_next.alive  = s2_alive;
    s3_side_next.t_snr  = clamp_term(64'(s2_pb >> SNR_SHIFT));
    s3_side_next.t_stab = clamp_term((64'(s2_hits) << TERM_FRAC_BITS) >> HIT_FRAC_BITS);
    s3_side_next.t_age  = clamp_term(64'(s2_pa >> REF_SHIFT));
    // above the speed limit the motion term drops out
    s3_side_next.t_motion = s2_over ? '0 : clamp_term(s2_pm >> REF_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // carry out of the 64-bit sum lands in bit 64
      s3_val  <= RAD_W'({1'b0, s2_sx} + {1'b0, s2_sy});
      s3_side <= s3_side_next;
    end
  end

  // ---------------------------------------------------------------------------
  // square-root pipeline: restoring method, one root bit per stage, radicand
  // pairs consumed from the top and shifted left as they are used
  // ---------------------------------------------------------------------------
  logic              sq_v    [SQ_STEPS];
  logic [RAD_W-1:0]  sq_val  [SQ_STEPS];
  logic [ROOT_W-1:0] sq_root [SQ_STEPS];
  logic [REM_W-1:0]  sq_rem  [SQ_STEPS];
  side_t             sq_side [SQ_STEPS];

  logic [RAD_W-1:0]  cur_val   [SQ_STEPS];
  logic [ROOT_W-1:0] cur_root  [SQ_STEPS];
  logic [REM_W-1:0]  cur_rem   [SQ_STEPS];
  side_t             cur_side  [SQ_STEPS];
  logic              cur_v     [SQ_STEPS];
  logic [REM_W+1:0]  rem_trial [SQ_STEPS];
  logic [REM_W+1:0]  trial     [SQ_STEPS];
  logic              fits      [SQ_STEPS];
  logic [REM_W+1:0]  rem_diff  [SQ_STEPS];

  always_comb begin
    for (int g = 0; g < SQ_STEPS; g++) begin
      if (g == 0) begin
        cur_v[g]    = s3_v;
        cur_val[g]  = s3_val;
        cur_root[g] = '0;
        cur_rem[g]  = '0;
        cur_side[g] = s3_side;
      end else begin
        cur_v[g]    = sq_v[g-1];
        cur_val[g]  = sq_val[g-1];
        cur_root[g] = sq_root[g-1];
        cur_rem[g]  = sq_rem[g-1];
        cur_side[g] = sq_side[g-1];
      end
      rem_trial[g] = {cur_rem[g], cur_val[g][RAD_W-1:RAD_W-2]};
      trial[g]     = {1'b0, cur_root[g], 2'b01};
      fits[g]      = rem_trial[g] >= trial[g];
      rem_diff[g]  = fits[g] ? (rem_trial[g] - trial[g]) : rem_trial[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < SQ_STEPS; g++) begin
        sq_v[g] <= 1'b0;
      end
    end else if (adv) begin
      for (int g = 0; g < SQ_STEPS; g++) begin
        sq_v[g] <= cur_v[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < SQ_STEPS; g++) begin
        sq_val[g]  <= {cur_val[g][RAD_W-3:0], 2'b00};
        sq_root[g] <= {cur_root[g][ROOT_W-2:0], fits[g]};
        // remainder stays at most twice the root, so the top bits are zero
        sq_rem[g]  <= rem_diff[g][REM_W-1:0];
        sq_side[g] <= cur_side[g];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // distance stage: root times the field reciprocal
  // ---------------------------------------------------------------------------
  logic        sd_v;
  logic [63:0] sd_pd;
  logic        sd_big;
  side_t       sd_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= 1'b0;
    end else if (adv) begin
      sd_v <= sq_v[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_pd   <= 64'(sq_root[SQ_STEPS-1][31:0]) * 64'(inv_half_field);
      // a root of 33 bits is always at least one field radius
      sd_big  <= sq_root[SQ_STEPS-1][ROOT_W-1];
      sd_side <= sq_side[SQ_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // weighting stage: centrality term, then each term times its weight
  // ---------------------------------------------------------------------------
  logic [TERM_W-1:0] ratio;
  logic [TERM_W-1:0] term [NUM_TERMS];

  always_comb begin
    // zero reciprocal leaves the track fully central
    if (inv_half_field == 32'd0) begin
      ratio = '0;
    end else if (sd_big) begin
      ratio = ONE_TERM;
    end else begin
      ratio = clamp_term(sd_pd >> REF_SHIFT);
    end
    term[0] = sd_side.t_snr;
    term[1] = sd_side.t_stab;
    term[2] = ONE_TERM - ratio;
    term[3] = sd_side.t_age;
    term[4] = sd_side.t_motion;
  end

  logic              sw_v;
  logic              sw_alive;
  logic [PROD_W-1:0] sw_prod [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_v <= 1'b0;
    end else if (adv) begin
      sw_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sw_alive <= sd_side.alive;
      for (int k = 0; k < NUM_TERMS; k++) begin
        sw_prod[k] <= PROD_W'(term_weights[k*WEIGHT_W +: WEIGHT_W]) * PROD_W'(term[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // final sum, rescale to Q3.20 and saturate; a dead track scores zero
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]   sum_all;
  logic [SUM_W-1:0]   sum_q;
  logic [SCORE_W-1:0] pipe_score;

  always_comb begin
    sum_all = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      sum_all = sum_all + SUM_W'(sw_prod[k]);
    end
    sum_q = sum_all >> SCORE_SHIFT;
    if (!sw_alive) begin
      pipe_score = '0;
    end else if (sum_q > SUM_W'(SCORE_MAX)) begin
      pipe_score = SCORE_MAX;
    end else begin
      pipe_score = sum_q[SCORE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register plus skid register: a score leaving the pipe while the
  // output is held parks in the skid register and stops the pipe next cycle
  // ---------------------------------------------------------------------------
  logic               pipe_out;
  logic               load_out;
  logic               load_skid;
  logic               score_valid_next;
  logic               skid_v_next;
  logic [SCORE_W-1:0] skid_score;

  always_comb begin
    pipe_out  = adv && sw_v;
    load_out  = 1'b0;
    load_skid = 1'b0;
    if (skid_v) begin
      score_valid_next = 1'b1;
      skid_v_next      = !score_ready;
    end else begin
      load_out         = pipe_out && (!score_valid || score_ready);
      load_skid        = pipe_out && score_valid && !score_ready;
      score_valid_next = pipe_out || (score_valid && !score_ready);
      skid_v_next      = load_skid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
      skid_v      <= 1'b0;
    end else begin
      score_valid <= score_valid_next;
      skid_v      <= skid_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v && score_ready) begin
      score <= skid_score;
    end else if (load_out) begin
      score <= pipe_score;
    end
    if (load_skid) begin
      skid_score <= pipe_score;
    end
  end

endmodule

>>> rtl/core/tps_checker.sv
`timescale 1ns / 1ps
// port-level checks for the track priority scorer, bound to the top level
// depends on tps_pkg and assert_macros.svh
`include "assert_macros.svh"

module tps_checker import tps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               track_ready,
  input logic               score_valid,
  input logic               score_ready,
  input logic [SCORE_W-1:0] score
);

  // held score stays put
  `TPS_ASSERT_NXT(a_score_hold, score_valid && !score_ready, score_valid && $stable(score))

  // saturation bound
  `TPS_ASSERT_IMP(a_score_max, score_valid, score <= SCORE_MAX)

  // back pressure only when a score is waiting
  `TPS_ASSERT_IMP(a_stall_has_score, !track_ready, score_valid)

  // full skid register drains only through the output
  `TPS_ASSERT_NXT(a_stall_holds, !track_ready && !score_ready, !track_ready)

endmodule

bind track_priority_score tps_checker u_tps_checker (.*);

>>> sim/track_priority_score_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the track priority scorer: directed table, then random requests
// depends on tps_pkg and track_priority_score; scores of untyped requests are predicted in-bench
module track_priority_score_tb;
  import tps_pkg::*;

  // pipeline is 39 deep; extra settling wait once the last score is in
  localparam int DRAIN_CYCLES    = 80;
  // cycles with no handshake at all before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 4000;
  // receiver hold-off long enough to fill the pipe and the skid register
  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 258;
  localparam int NUM_MODES       = 3;
  localparam int DIR_ROWS        = 20;

  // idle percentages per mode: receiver slow first, sender slow second, then flat out
  localparam int SEND_IDLE [NUM_MODES] = '{38, 80, 0};
  localparam int RECV_IDLE [NUM_MODES] = '{80, 38, 0};

  typedef enum logic [2:0] {
    SET_RESET,
    SET_FULL,
    SET_EDGE,
    SET_NULL,
    SET_MID
  } setting_id_t;

  // register image, in register-index order
  typedef struct packed {
    logic [59:0] term_weights;
    logic [31:0] inv_snr_ref;
    logic [31:0] inv_age_ref;
    logic [31:0] inv_half_field;
    logic [31:0] inv_speed_ref;
    logic [31:0] speed_limit;
    logic [31:0] aim_x;
    logic [31:0] aim_y;
  } tps_setting_t;

  typedef struct packed {
    logic        alive;
    logic [15:0] brightness;
    logic [12:0] hit_ratio;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] age_count;
    logic [31:0] rel_speed;
  } track_req_t;

  typedef struct packed {
    setting_id_t        setting;
    track_req_t         req;
    logic               typed;    // score below is taken as is
    logic [SCORE_W-1:0] score;
  } dir_row_t;

  localparam logic [59:0] ALL_WEIGHTS_MAX = 60'hFFF_FFF_FFF_FFF_FFF;

  // fixed register settings used by the directed table
  tps_setting_t fixed_settings [5] = '{
    '{60'd0, INV_RESET, INV_RESET, INV_RESET, INV_RESET, 32'd0, 32'd0, 32'd0},
    '{ALL_WEIGHTS_MAX, INV_RESET, INV_RESET, INV_RESET, INV_RESET, 32'd0, 32'd0, 32'd0},
    '{ALL_WEIGHTS_MAX, INV_RESET, INV_RESET, INV_RESET, INV_RESET, 32'd1000,
      32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{ALL_WEIGHTS_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
      32'h8000_0000, 32'h8000_0000},
    '{60'h123_456_789_ABC_DEF, 32'h0100_0000, 32'h0010_0000, 32'h0000_4000,
      32'h0001_0000, 32'd5000000, -32'sd100000, 32'sd250000}
  };

  // directed requests; settings switch only between rows, with the pipe drained
  dir_row_t dir_rows [DIR_ROWS] = '{
    // weights are zero out of reset, so anything scores zero
    '{SET_RESET, '{1'b1, 16'hFFFF, 13'd4096, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
      32'hFFFF_FFFF}, 1'b1, 23'd0},
    '{SET_RESET, '{1'b1, 16'h0000, 13'd0, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b1, 23'd0},
    // dead track with every other field at its maximum
    '{SET_FULL, '{1'b0, 16'hFFFF, 13'h1FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
      32'hFFFF_FFFF}, 1'b1, 23'd0},
    // all five terms at one with full weights
    '{SET_FULL, '{1'b1, 16'hFFFF, 13'd4096, 32'h0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF},
      1'b1, 23'd5241600},
    // hit ratio above one clamps to one
    '{SET_FULL, '{1'b1, 16'hFFFF, 13'h1FFF, 32'h0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF},
      1'b1, 23'd5241600},
    '{SET_FULL, '{1'b1, 16'h0000, 13'd0, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b0, 23'd0},
    '{SET_FULL, '{1'b1, 16'h0001, 13'd1, 32'h1, 32'hFFFF_FFFF, 16'h1, 32'h1}, 1'b0, 23'd0},
    '{SET_FULL, '{1'b1, 16'h8000, 13'd2048, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000,
      32'h8000_0000}, 1'b0, 23'd0},
    // aim at the far corner: distance needs 33 bits; speed right at the limit
    '{SET_EDGE, '{1'b1, 16'hFFFF, 13'd4096, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
      32'd1000}, 1'b0, 23'd0},
    // one above the speed limit kills the motion term
    '{SET_EDGE, '{1'b1, 16'hFFFF, 13'd4096, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
      32'd1001}, 1'b0, 23'd0},
    '{SET_EDGE, '{1'b1, 16'hFFFF, 13'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
      32'd0}, 1'b0, 23'd0},
    '{SET_EDGE, '{1'b1, 16'h0100, 13'd4096, 32'h0, 32'h7FFF_FFFF, 16'd1, 32'hFFFF_FFFF},
      1'b0, 23'd0},
    '{SET_EDGE, '{1'b0, 16'h1234, 13'd100, 32'h0, 32'h0, 16'd5, 32'd5}, 1'b1, 23'd0},
    // zero reciprocals: scaled terms vanish, centrality stays one even far out
    '{SET_NULL, '{1'b1, 16'hFFFF, 13'h1FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
      32'hFFFF_FFFF}, 1'b0, 23'd0},
    '{SET_NULL, '{1'b1, 16'h1234, 13'h0ABC, 32'h0, 32'h0, 16'h0FFF, 32'hFFFF_FFFF},
      1'b0, 23'd0},
    // mid-range references: terms mostly land strictly between zero and one
    '{SET_MID, '{1'b1, 16'h0A80, 13'd3072, -32'sd100000, 32'sd250000, 16'd2048,
      32'd4000000}, 1'b0, 23'd0},
    '{SET_MID, '{1'b1, 16'h0100, 13'd4096, -32'sd97000, 32'sd246000, 16'hFFFF,
      32'd5000000}, 1'b0, 23'd0},
    '{SET_MID, '{1'b1, 16'h0040, 13'd1024, -32'sd97000, 32'sd246000, 16'd300,
      32'd5000001}, 1'b0, 23'd0},
    '{SET_MID, '{1'b1, 16'h3000, 13'd512, 32'sd300000, -32'sd400000, 16'd40000,
      32'd65536}, 1'b0, 23'd0},
    '{SET_MID, '{1'b0, 16'hFFFF, 13'd4096, 32'sd0, 32'sd0, 16'hFFFF, 32'd0}, 1'b1, 23'd0}
  };

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  track_valid     = 1'b0;
  logic                  track_ready;
  logic                  track_alive     = 1'b0;
  logic [15:0]           mean_brightness = '0;
  logic [12:0]           hit_ratio       = '0;
  logic signed [31:0]    pos_x           = '0;
  logic signed [31:0]    pos_y           = '0;
  logic [15:0]           age_count       = '0;
  logic [31:0]           rel_speed       = '0;

  logic                  score_valid;
  logic                  score_ready = 1'b0;
  logic [SCORE_W-1:0]    score;

  // bench copy of the register file, updated when a write is taken
  tps_setting_t live_cfg = '{60'd0, INV_RESET, INV_RESET, INV_RESET, INV_RESET,
                             32'd0, 32'd0, 32'd0};

  logic [SCORE_W-1:0] pending_scores [$];
  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  hold_start     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  track_priority_score u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .track_valid     (track_valid),
    .track_ready     (track_ready),
    .track_alive     (track_alive),
    .mean_brightness (mean_brightness),
    .hit_ratio       (hit_ratio),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .age_count       (age_count),
    .rel_speed       (rel_speed),
    .score_valid     (score_valid),
    .score_ready     (score_ready),
    .score           (score)
  );

  // ---------------------------------------------------------------------------
  // score predictor, working from the bench register copy
  // ---------------------------------------------------------------------------
  function automatic logic [TERM_W-1:0] clamp_unit(input logic [63:0] v);
    return (v > 64'(ONE_TERM)) ? ONE_TERM : v[TERM_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] predict_score(input track_req_t r);
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;
    logic [65:0]        radicand, rem, trial;
    logic [32:0]        root;
    logic [TERM_W-1:0]  ratio;
    logic [TERM_W-1:0]  terms [NUM_TERMS];
    logic [31:0]        acc;
    if (!r.alive) return '0;

    terms[0] = clamp_unit((64'(r.brightness) * 64'(live_cfg.inv_snr_ref)) >> SNR_SHIFT);
    terms[1] = clamp_unit((64'(r.hit_ratio) << TERM_FRAC_BITS) >> HIT_FRAC_BITS);

    // distance from boresight over 33-bit signed differences, exact 66-bit radicand
    dx = $signed({r.pos_x[31], r.pos_x}) - $signed({live_cfg.aim_x[31], live_cfg.aim_x});
    dy = $signed({r.pos_y[31], r.pos_y}) - $signed({live_cfg.aim_y[31], live_cfg.aim_y});
    ax = (dx < 0) ? 33'(-dx) : 33'(dx);
    ay = (dy < 0) ? 33'(-dy) : 33'(dy);
    radicand = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);

    // restoring square root, two radicand bits per step
    root = '0;
    rem  = '0;
    for (int i = SQ_STEPS - 1; i >= 0; i--) begin
      rem   = (rem << 2) | 66'(radicand[2*i +: 2]);
      trial = (66'(root) << 2) | 66'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 33'd1;
      end else begin
        root = root << 1;
      end
    end

    if (live_cfg.inv_half_field == '0) ratio = '0;
    else if (root[32]) ratio = ONE_TERM;
    else ratio = clamp_unit((64'(root[31:0]) * 64'(live_cfg.inv_half_field)) >> REF_SHIFT);
    terms[2] = ONE_TERM - ratio;

    terms[3] = clamp_unit((64'(r.age_count) * 64'(live_cfg.inv_age_ref)) >> REF_SHIFT);

    if (live_cfg.speed_limit != '0 && r.rel_speed > live_cfg.speed_limit)
      terms[4] = '0;
    else
      terms[4] = clamp_unit((64'(r.rel_speed) * 64'(live_cfg.inv_speed_ref)) >> REF_SHIFT);

    acc = '0;
    for (int k = 0; k < NUM_TERMS; k++)
      acc = acc + 32'(live_cfg.term_weights[WEIGHT_W*k +: WEIGHT_W]) * 32'(terms[k]);
    acc = acc >> SCORE_SHIFT;
    return (acc > 32'(SCORE_MAX)) ? SCORE_MAX : acc[SCORE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // random settings and requests
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_recip();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic tps_setting_t rand_setting();
    tps_setting_t s;
    for (int k = 0; k < NUM_TERMS; k++) begin
      case ($urandom_range(0, 7))
        0:       s.term_weights[WEIGHT_W*k +: WEIGHT_W] = '0;
        1:       s.term_weights[WEIGHT_W*k +: WEIGHT_W] = '1;
        default: s.term_weights[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_W'($urandom);
      endcase
    end
    s.inv_snr_ref    = pick_recip();
    s.inv_age_ref    = pick_recip();
    s.inv_half_field = pick_recip();
    s.inv_speed_ref  = pick_recip();
    case ($urandom_range(0, 9))
      0, 1, 2: s.speed_limit = 32'd0;
      3:       s.speed_limit = 32'hFFFF_FFFF;
      default: s.speed_limit = $urandom >> $urandom_range(0, 31);
    endcase
    // boresight sometimes anywhere, mostly within a modest window
    s.aim_x = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 8);
    s.aim_y = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 8);
    return s;
  endfunction

  function automatic track_req_t rand_track();
    track_req_t         r;
    logic signed [31:0] off_x, off_y;
    r.alive      = ($urandom_range(0, 9) != 0);
    r.brightness = 16'($urandom);
    r.hit_ratio  = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
    // most tracks sit near boresight at a random scale so centrality is graded
    off_x = $urandom;
    off_y = $urandom;
    off_x = off_x >>> $urandom_range(0, 31);
    off_y = off_y >>> $urandom_range(0, 31);
    if ($urandom_range(0, 9) < 6) begin
      r.pos_x = live_cfg.aim_x + off_x;
      r.pos_y = live_cfg.aim_y + off_y;
    end else begin
      r.pos_x = $urandom;
      r.pos_y = $urandom;
    end
    r.age_count = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    // probe either side of the speed limit now and then
    if (live_cfg.speed_limit != '0 && $urandom_range(0, 3) == 0)
      r.rel_speed = live_cfg.speed_limit + 32'($urandom_range(0, 2)) - 32'd1;
    else
      r.rel_speed = $urandom >> $urandom_range(0, 31);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes: setup cycle, then access cycle until pready
  // ---------------------------------------------------------------------------
  task automatic write_reg(input tps_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << 3;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TERM_WEIGHTS:   live_cfg.term_weights   = value[59:0];
      REG_INV_SNR_REF:    live_cfg.inv_snr_ref    = value[31:0];
      REG_INV_AGE_REF:    live_cfg.inv_age_ref    = value[31:0];
      REG_INV_HALF_FIELD: live_cfg.inv_half_field = value[31:0];
      REG_INV_SPEED_REF:  live_cfg.inv_speed_ref  = value[31:0];
      REG_SPEED_LIMIT:    live_cfg.speed_limit    = value[31:0];
      REG_AIM_X:          live_cfg.aim_x          = value[31:0];
      REG_AIM_Y:          live_cfg.aim_y          = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input tps_setting_t s);
    write_reg(REG_TERM_WEIGHTS,   64'(s.term_weights));
    write_reg(REG_INV_SNR_REF,    64'(s.inv_snr_ref));
    write_reg(REG_INV_AGE_REF,    64'(s.inv_age_ref));
    write_reg(REG_INV_HALF_FIELD, 64'(s.inv_half_field));
    write_reg(REG_INV_SPEED_REF,  64'(s.inv_speed_ref));
    write_reg(REG_SPEED_LIMIT,    64'(s.speed_limit));
    write_reg(REG_AIM_X,          64'(s.aim_x));
    write_reg(REG_AIM_Y,          64'(s.aim_y));
  endtask

  // ---------------------------------------------------------------------------
  // request sender: random gaps, then valid held until the handshake
  // ---------------------------------------------------------------------------
  task automatic send_track(input track_req_t r, input logic typed,
                            input logic [SCORE_W-1:0] typed_score);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      track_valid <= 1'b0;
      @(negedge clk);
    end
    track_valid     <= 1'b1;
    track_alive     <= r.alive;
    mean_brightness <= r.brightness;
    hit_ratio       <= r.hit_ratio;
    pos_x           <= r.pos_x;
    pos_y           <= r.pos_y;
    age_count       <= r.age_count;
    rel_speed       <= r.rel_speed;
    do @(posedge clk); while (!track_ready);
    // request taken at this edge; settings are stable while requests are in flight
    pending_scores.push_back(typed ? typed_score : predict_score(r));
  endtask

  // drop valid and wait for every outstanding score
  task automatic drain_scores();
    @(negedge clk);
    track_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // score receiver: random ready, with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        // long stall so the pipe fills and track_ready drops
        hold_done = 1'b1;
        score_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      score_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each taken score with the oldest prediction
  always @(posedge clk) begin
    if (!rst && score_valid && score_ready) begin
      if (pending_scores.size() == 0) begin
        $error("score: unexpected result %0d with no prediction pending", score);
        mismatch_count++;
      end else begin
        logic [SCORE_W-1:0] want;
        want = pending_scores.pop_front();
        if (score !== want) begin
          $error("score: expected %0d, actual %0d", want, score);
          mismatch_count++;
        end
      end
    end
  end

  // hang detector: any request, score or write handshake restarts the count
  always @(posedge clk) begin
    if (rst || (track_valid && track_ready) || (score_valid && score_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    setting_id_t cur_setting;
    cur_setting = SET_RESET;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, settings switched only with the pipe empty
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].setting != cur_setting) begin
        drain_scores();
        cur_setting = dir_rows[i].setting;
        apply_setting(fixed_settings[int'(cur_setting)]);
      end
      send_track(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].score);
    end

    // random requests: two settings per idling mode
    for (int m = 0; m < NUM_MODES; m++) begin
      for (int p = 0; p < 2; p++) begin
        drain_scores();
        send_idle_pct = SEND_IDLE[m];
        recv_idle_pct = RECV_IDLE[m];
        apply_setting(rand_setting());
        // with no idling on the sender, stall the receiver once for a long stretch
        if (m == NUM_MODES - 1 && p == 1) hold_start = 1'b1;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
          send_track(rand_track(), 1'b0, '0);
      end
    end

    drain_scores();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_scores.size() != 0) begin
      $error("score: %0d predictions never matched by a result", pending_scores.size());
    end

    if (mismatch_count == 0 && pending_scores.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
